@@ src/lhs_pkg.sv @@
// Package: shared constants, types and a saturation helper for the Langevin step block.
package lhs_pkg;

   localparam int TRAJECTORIES_DEFAULT  = 1024;
   localparam int FRACTION_BITS_DEFAULT = 30;
   localparam int COEF_W  = 31;
   localparam int DATA_W  = 32;
   localparam int GAUSS_W = 16;
   localparam int IDX_W   = 10;
   localparam int CSR_IDX_W = 3;
   localparam int NOISE_SHIFT = 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DECAY       = 3'd0,
      CSR_NOISE       = 3'd1,
      CSR_SPRING      = 3'd2,
      CSR_TIME_STEP   = 3'd3,
      CSR_START_POS   = 3'd4,
      CSR_START_VEL   = 3'd5
   } csr_index_type;

   // Saturate a 64-bit signed value to 32 bits.
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [63:0] max_v;
      logic signed [63:0] min_v;
      max_v = 64'sd2147483647;
      min_v = -64'sd2147483648;
      if (v > max_v) sat32 = 32'sh7FFFFFFF;
      else if (v < min_v) sat32 = 32'sh80000000;
      else sat32 = v[DATA_W-1:0];
   endfunction

endpackage

@@ src/lhs_mul.sv @@
// Registered signed multiply with arithmetic right shift.
module lhs_mul
   import lhs_pkg::*;
#(
   parameter int SHIFT = 30
) (
   input  logic                     clock,
   input  logic                     enable,
   input  logic signed [DATA_W-1:0] a,
   input  logic signed [DATA_W-1:0] b,
   output logic signed [63:0]       product_ff
);
   logic signed [63:0] product_in;

   assign product_in = (64'(a) * 64'(b)) >>> SHIFT;

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= product_in;
      end
   end
endmodule

@@ src/langevin_harmonic_step.sv @@
// Top level: pipelined Langevin velocity-Verlet step over a store of trajectories.
//
// Usage:
//   Input channel (req_*): one beat per particle update carries two Q4.12
//   Gaussian samples and a restart flag. Trajectories are taken in order,
//   0 .. TRAJECTORIES-1, then the index wraps. A restart loads
//   start_position / start_velocity for that trajectory before stepping.
//   Result channel (rsp_*): one beat per input beat, in order, with the new
//   position and velocity, the trajectory index and, on the last trajectory
//   of a sweep (rsp_sweep_end), the means and mean squares of the sweep.
//   Configuration (csr_*): plain write port; write it only while idle, as the block does not enforce this.
// Throughput: one beat per cycle when neither a stall nor a trajectory
//   hazard holds the input. The pipeline has 12 register stages; the depth
//   is set by the chain of dependent multiply/shift stages, each with its
//   own register.
// Stall: the whole pipeline advances together; when rsp_valid is high and
//   rsp_ready low, nothing moves and req_ready drops, so no beat is lost or
//   repeated. The output register keeps the result until taken.
// Reset: synchronous, active high. Clears valid bits, index, sums and
//   restores register defaults. The stores hold no reset value; the user
//   must restart a trajectory before its entry is read, which the block
//   does not enforce. With fewer than ten trajectories a beat waits at the
//   input (req_ready low) while its trajectory is still in stages 0..8.
module langevin_harmonic_step
   import lhs_pkg::*;
#(
   parameter int TRAJECTORIES  = TRAJECTORIES_DEFAULT,
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [GAUSS_W-1:0] req_gauss_first,
   input  logic signed [GAUSS_W-1:0] req_gauss_second,
   input  logic                      req_restart,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [DATA_W-1:0]  rsp_position,
   output logic signed [DATA_W-1:0]  rsp_velocity,
   output logic [IDX_W-1:0]          rsp_trajectory_index,
   output logic                      rsp_sweep_end,
   output logic signed [DATA_W-1:0]  rsp_mean_position,
   output logic signed [DATA_W-1:0]  rsp_mean_velocity,
   output logic [DATA_W-1:0]         rsp_mean_sq_position,
   output logic [DATA_W-1:0]         rsp_mean_sq_velocity,
   input  logic                      csr_write_enable,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [DATA_W-1:0]         csr_write_data
);
   localparam int TW = $clog2(TRAJECTORIES);
   localparam int STAGES = 12;
   localparam int SUM_W = 64;
   localparam int WB_STAGE = 9;

   // ---------------- configuration registers ----------------
   logic [COEF_W-1:0] decay_ff, noise_ff, spring_ff, dt_ff;
   logic signed [DATA_W-1:0] start_pos_ff, start_vel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff     <= 31'd1072639040;
         noise_ff     <= 31'd18000;
         spring_ff    <= 31'd382000;
         dt_ff        <= 31'd107374182;
         start_pos_ff <= 32'sd107374182;
         start_vel_ff <= 32'sd2147484;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DECAY:     decay_ff     <= csr_write_data[COEF_W-1:0];
            CSR_NOISE:     noise_ff     <= csr_write_data[COEF_W-1:0];
            CSR_SPRING:    spring_ff    <= csr_write_data[COEF_W-1:0];
            CSR_TIME_STEP: dt_ff        <= csr_write_data[COEF_W-1:0];
            CSR_START_POS: start_pos_ff <= csr_write_data;
            CSR_START_VEL: start_vel_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   logic signed [DATA_W-1:0] c_s, n_s, k_s, dt_s;
   assign c_s  = {1'b0, decay_ff};
   assign n_s  = {1'b0, noise_ff};
   assign k_s  = {1'b0, spring_ff};
   assign dt_s = {1'b0, dt_ff};

   // ---------------- pipeline control ----------------
   logic advance;
   logic hazard;
   logic [STAGES-1:0] vld_ff;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance && !hazard;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[STAGES-2:0], req_valid && !hazard};
      end
   end
   assign rsp_valid = vld_ff[STAGES-1];

   // per-stage side-band carried along: index, restart, gauss samples
   logic [TW-1:0] idx_ff [STAGES];
   logic          rst_ff [STAGES];
   logic signed [GAUSS_W-1:0] g1_ff [STAGES];
   logic signed [GAUSS_W-1:0] g2_ff [STAGES];
   logic [TW-1:0] next_index_ff;

   // same trajectory still ahead of write-back: hold the input
   always_comb begin
      hazard = 1'b0;
      for (int s = 0; s < WB_STAGE; s++) begin
         if (vld_ff[s] && (idx_ff[s] == next_index_ff)) begin
            hazard = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_index_ff <= '0;
      end else if (req_valid && req_ready) begin
         next_index_ff <= (next_index_ff == TW'(TRAJECTORIES - 1)) ? '0
                                                                   : next_index_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         idx_ff[0] <= next_index_ff;
         rst_ff[0] <= req_restart;
         g1_ff[0]  <= req_gauss_first;
         g2_ff[0]  <= req_gauss_second;
         for (int s = 1; s < STAGES; s++) begin
            idx_ff[s] <= idx_ff[s-1];
            rst_ff[s] <= rst_ff[s-1];
            g1_ff[s]  <= g1_ff[s-1];
            g2_ff[s]  <= g2_ff[s-1];
         end
      end
   end

   // ---------------- stores ----------------
   logic signed [DATA_W-1:0] pos_mem [TRAJECTORIES];
   logic signed [DATA_W-1:0] vel_mem [TRAJECTORIES];
   logic signed [DATA_W-1:0] pos_rd_ff, vel_rd_ff;
   logic                     wb_en;
   logic [TW-1:0]            wb_idx;
   logic signed [DATA_W-1:0] wb_pos, wb_vel;

   // stage 0 -> 1: read at the index now in stage 0
   always_ff @(posedge clock) begin
      if (advance) begin
         pos_rd_ff <= pos_mem[idx_ff[0]];
         vel_rd_ff <= vel_mem[idx_ff[0]];
      end
      if (wb_en) begin
         pos_mem[wb_idx] <= wb_pos;
         vel_mem[wb_idx] <= wb_vel;
      end
   end

   // Forwarding: results still in flight for the same trajectory (small counts).
   logic signed [DATA_W-1:0] fwd_pos [STAGES];
   logic signed [DATA_W-1:0] fwd_vel [STAGES];
   logic                     fwd_hit [STAGES];

   // stage 1: pick start values or store data, with forwarding
   logic signed [DATA_W-1:0] x0, v0;
   always_comb begin
      x0 = pos_rd_ff;
      v0 = vel_rd_ff;
      for (int s = STAGES-1; s >= 2; s--) begin
         if (fwd_hit[s]) begin
            x0 = fwd_pos[s];
            v0 = fwd_vel[s];
         end
      end
      if (rst_ff[1]) begin
         x0 = start_pos_ff;
         v0 = start_vel_ff;
      end
   end

   // stage 1 -> 2: k*x, c*v, n*g1
   logic signed [63:0] kx_ff, cv_ff, ng1_ff;
   logic signed [DATA_W-1:0] x1_ff;
   lhs_mul #(.SHIFT(FRACTION_BITS)) u_kx (.clock, .enable(advance), .a(x0), .b(k_s),
                                         .product_ff(kx_ff));
   lhs_mul #(.SHIFT(FRACTION_BITS)) u_cv (.clock, .enable(advance), .a(v0), .b(c_s),
                                         .product_ff(cv_ff));
   lhs_mul #(.SHIFT(NOISE_SHIFT)) u_ng1 (.clock, .enable(advance), .a(32'(g1_ff[1])),
                                         .b(n_s), .product_ff(ng1_ff));

   // stage 2 -> 3: a = sat(-kx); a*dt/2
   logic signed [DATA_W-1:0] a1;
   logic signed [63:0] adt1_ff;
   assign a1 = sat32(-kx_ff);
   lhs_mul #(.SHIFT(FRACTION_BITS+1)) u_adt1 (.clock, .enable(advance), .a(a1), .b(dt_s),
                                            .product_ff(adt1_ff));
   logic signed [63:0] cv2_ff, ng1_2_ff;
   logic signed [DATA_W-1:0] x2_ff;

   // stage 3: v_half; stage 3 -> 4: vh*dt
   logic signed [DATA_W-1:0] vh3;
   assign vh3 = sat32(64'(sat32(adt1_ff)) + cv2_ff + ng1_2_ff);
   logic signed [63:0] vhdt_ff;
   lhs_mul #(.SHIFT(FRACTION_BITS)) u_vhdt (.clock, .enable(advance), .a(vh3), .b(dt_s),
                                           .product_ff(vhdt_ff));
   logic signed [DATA_W-1:0] x3_ff, vh4_ff;

   // stage 4: x' ; register
   logic signed [DATA_W-1:0] xn4, xn5_ff, vh5_ff;
   assign xn4 = sat32(64'(x3_ff) + vhdt_ff);

   // stage 5 -> 6: k*x', c*vh, n*g2
   logic signed [63:0] kx2_ff, cvh_ff, ng2_ff;
   lhs_mul #(.SHIFT(FRACTION_BITS)) u_kx2 (.clock, .enable(advance), .a(xn5_ff), .b(k_s),
                                          .product_ff(kx2_ff));
   lhs_mul #(.SHIFT(FRACTION_BITS)) u_cvh (.clock, .enable(advance), .a(vh5_ff), .b(c_s),
                                          .product_ff(cvh_ff));
   lhs_mul #(.SHIFT(NOISE_SHIFT)) u_ng2 (.clock, .enable(advance), .a(32'(g2_ff[5])),
                                         .b(n_s), .product_ff(ng2_ff));
   logic signed [DATA_W-1:0] xn6_ff;

   // stage 6 -> 7: a'*dt/2
   logic signed [DATA_W-1:0] a2;
   logic signed [63:0] adt2_ff, cvh7_ff, ng2_7_ff;
   logic signed [DATA_W-1:0] xn7_ff;
   assign a2 = sat32(-kx2_ff);
   lhs_mul #(.SHIFT(FRACTION_BITS+1)) u_adt2 (.clock, .enable(advance), .a(a2), .b(dt_s),
                                            .product_ff(adt2_ff));

   // stage 7 -> 8: c*(a'dt/2)
   logic signed [63:0] cadt_ff, cvh8_ff, ng2_8_ff;
   logic signed [DATA_W-1:0] xn8_ff;
   lhs_mul #(.SHIFT(FRACTION_BITS)) u_cadt (.clock, .enable(advance), .a(sat32(adt2_ff)),
                                           .b(c_s), .product_ff(cadt_ff));

   // stage 8: v'
   logic signed [DATA_W-1:0] vn8;
   assign vn8 = sat32(cadt_ff + cvh8_ff + ng2_8_ff);

   // stage 9: write back and squares
   logic signed [DATA_W-1:0] xn9_ff, vn9_ff;
   logic signed [63:0] xsq_ff, vsq_ff;
   lhs_mul #(.SHIFT(0)) u_xsq (.clock, .enable(advance), .a(xn8_ff), .b(xn8_ff),
                               .product_ff(xsq_ff));
   lhs_mul #(.SHIFT(0)) u_vsq (.clock, .enable(advance), .a(vn8), .b(vn8),
                               .product_ff(vsq_ff));

   always_ff @(posedge clock) begin
      if (advance) begin
         x1_ff    <= x0;
         x2_ff    <= x1_ff;
         cv2_ff   <= cv_ff;
         ng1_2_ff <= ng1_ff;
         x3_ff    <= x2_ff;
         vh4_ff   <= vh3;
         xn5_ff   <= xn4;
         vh5_ff   <= vh4_ff;
         xn6_ff   <= xn5_ff;
         xn7_ff   <= xn6_ff;
         cvh7_ff  <= cvh_ff;
         ng2_7_ff <= ng2_ff;
         xn8_ff   <= xn7_ff;
         cvh8_ff  <= cvh7_ff;
         ng2_8_ff <= ng2_7_ff;
         xn9_ff   <= xn8_ff;
         vn9_ff   <= vn8;
      end
   end

   // Forward path: once x' / v' known, stages 9..11 hold final values.
   logic signed [DATA_W-1:0] xn10_ff, vn10_ff, xn11_ff, vn11_ff;
   always_comb begin
      for (int s = 0; s < STAGES; s++) begin
         fwd_pos[s] = xn11_ff;
         fwd_vel[s] = vn11_ff;
         fwd_hit[s] = 1'b0;
      end
      // Entries in stages 2..8 never share a trajectory with stage 1: the
      // input is held back while the same trajectory sits in stages 0..8.
      fwd_pos[9]  = xn9_ff;  fwd_vel[9]  = vn9_ff;
      fwd_pos[10] = xn10_ff; fwd_vel[10] = vn10_ff;
      fwd_pos[11] = xn11_ff; fwd_vel[11] = vn11_ff;
      for (int s = 9; s < STAGES; s++) begin
         fwd_hit[s] = vld_ff[s] && (idx_ff[s] == idx_ff[1]);
      end
   end

   assign wb_en  = advance && vld_ff[9];
   assign wb_idx = idx_ff[9];
   assign wb_pos = xn9_ff;
   assign wb_vel = vn9_ff;

   // stage 9 -> 10: accumulate sums
   logic signed [SUM_W-1:0] sum_x_ff, sum_v_ff;
   logic [SUM_W-1:0]        sum_xx_ff, sum_vv_ff;
   logic signed [SUM_W-1:0] sum_x_in, sum_v_in;
   logic [SUM_W-1:0]        sum_xx_in, sum_vv_in;
   logic                     last9;
   logic [SUM_W-1:0]         xsq_q, vsq_q;
   assign last9 = (idx_ff[9] == TW'(TRAJECTORIES - 1));
   assign xsq_q = SUM_W'(xsq_ff) >> FRACTION_BITS;
   assign vsq_q = SUM_W'(vsq_ff) >> FRACTION_BITS;
   assign sum_x_in  = sum_x_ff  + SUM_W'(xn9_ff);
   assign sum_v_in  = sum_v_ff  + SUM_W'(vn9_ff);
   assign sum_xx_in = sum_xx_ff + xsq_q;
   assign sum_vv_in = sum_vv_ff + vsq_q;

   logic signed [SUM_W-1:0] tot_x_ff, tot_v_ff;
   logic [SUM_W-1:0]        tot_xx_ff, tot_vv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff  <= '0;
         sum_v_ff  <= '0;
         sum_xx_ff <= '0;
         sum_vv_ff <= '0;
      end else if (advance && vld_ff[9]) begin
         if (last9) begin
            sum_x_ff  <= '0;
            sum_v_ff  <= '0;
            sum_xx_ff <= '0;
            sum_vv_ff <= '0;
         end else begin
            sum_x_ff  <= sum_x_in;
            sum_v_ff  <= sum_v_in;
            sum_xx_ff <= sum_xx_in;
            sum_vv_ff <= sum_vv_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tot_x_ff  <= sum_x_in >>> TW;
         tot_v_ff  <= sum_v_in >>> TW;
         tot_xx_ff <= sum_xx_in >> TW;
         tot_vv_ff <= sum_vv_in >> TW;
         xn10_ff   <= xn9_ff;
         vn10_ff   <= vn9_ff;
      end
   end

   // stage 10 -> 11: saturate and form the result
   logic signed [DATA_W-1:0] mx_ff, mv_ff;
   logic [DATA_W-1:0]        mxx_ff, mvv_ff;
   logic                     end_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         end_ff  <= (idx_ff[10] == TW'(TRAJECTORIES - 1));
         mx_ff   <= '0;
         mv_ff   <= '0;
         mxx_ff  <= '0;
         mvv_ff  <= '0;
         if (idx_ff[10] == TW'(TRAJECTORIES - 1)) begin
            mx_ff  <= sat32(tot_x_ff);
            mv_ff  <= sat32(tot_v_ff);
            mxx_ff <= (tot_xx_ff[SUM_W-1:DATA_W] != '0) ? '1 : tot_xx_ff[DATA_W-1:0];
            mvv_ff <= (tot_vv_ff[SUM_W-1:DATA_W] != '0) ? '1 : tot_vv_ff[DATA_W-1:0];
         end
         xn11_ff <= xn10_ff;
         vn11_ff <= vn10_ff;
      end
   end

   assign rsp_position         = xn11_ff;
   assign rsp_velocity         = vn11_ff;
   assign rsp_trajectory_index = IDX_W'(idx_ff[STAGES-1]);
   assign rsp_sweep_end        = end_ff;
   assign rsp_mean_position    = mx_ff;
   assign rsp_mean_velocity    = mv_ff;
   assign rsp_mean_sq_position = mxx_ff;
   assign rsp_mean_sq_velocity = mvv_ff;

endmodule

@@ src/lhs_checker.sv @@
// Checker: port-level properties of the Langevin step block, bound to the top level.
module lhs_checker
   import lhs_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_sweep_end,
   input logic [DATA_W-1:0] rsp_mean_sq_position,
   input logic [DATA_W-1:0] rsp_position
);
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result valid right after reset");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready) else $error("accepted beat during stall");

   a_stats_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_sweep_end) |-> (rsp_mean_sq_position == '0))
      else $error("statistics nonzero outside sweep end");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_position)))
      else $error("result changed under stall");
endmodule

bind langevin_harmonic_step lhs_checker u_lhs_checker (
   .clock, .reset, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_sweep_end, .rsp_mean_sq_position, .rsp_position
);
